// ----- hw/rtl/hex_fragment_reassembly_parser_macros.svh -----
// Assertion macros shared by the fragment reassembly parser RTL.
`ifndef HEX_FRAGMENT_REASSEMBLY_PARSER_MACROS_SVH
`define HEX_FRAGMENT_REASSEMBLY_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define HFRP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hfrp assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define HFRP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hfrp assertion failed");
`else
`define HFRP_ASSERT_NOW(lbl, ante, cons)
`define HFRP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/hfrp_pkg.sv -----
// Types, constants and tables of the fragment reassembly parser.
package hfrp_pkg;

    localparam int MAX_BYTES = 1024;
    localparam int NIB_W     = $clog2(2 * MAX_BYTES + 1);
    localparam logic [NIB_W-1:0] NIB_LIMIT = NIB_W'(2 * MAX_BYTES);

    // Field numbers within one message.
    localparam logic [2:0] FIELD_NONE  = 3'd0;
    localparam logic [2:0] FIELD_FLAG  = 3'd1;
    localparam logic [2:0] FIELD_ID    = 3'd2;
    localparam logic [2:0] FIELD_COUNT = 3'd3;
    localparam logic [2:0] FIELD_DATA  = 3'd4;
    localparam logic [2:0] FIELD_EXTRA = 3'd5;
    localparam logic [2:0] FIELD_STOP  = 3'd7;

    // Flag matcher codes; 1 to 7 are partial matches of the trigger word.
    localparam logic [3:0] FLAG_EMPTY = 4'd0;
    localparam logic [3:0] FLAG_AT    = 4'd1;
    localparam logic [3:0] FLAG_TRIG  = 4'd8;
    localparam logic [3:0] FLAG_F     = 4'd9;
    localparam logic [3:0] FLAG_BAD   = 4'd10;

    localparam logic [1:0] DEC_UNDECIDED = 2'd0;
    localparam logic [1:0] DEC_ACCEPT    = 2'd1;
    localparam logic [1:0] DEC_REJECT    = 2'd2;

    localparam logic [1:0] VERDICT_NONE     = 2'd0;
    localparam logic [1:0] VERDICT_COMPLETE = 2'd1;
    localparam logic [1:0] VERDICT_TRIGGER  = 2'd2;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_AT  = 8'h40;
    localparam logic [7:0] CHAR_F   = 8'h46;
    localparam logic [7:0] CHAR_SEMI = 8'h3b;
    localparam logic [7:0] CHAR_CR  = 8'h0d;
    localparam logic [7:0] CHAR_LF  = 8'h0a;

    // Characters of "@trigger", indexed by the matcher state.
    localparam logic [7:0] TRIG_CHARS [8] = '{8'h40, 8'h74, 8'h72, 8'h69,
                                              8'h67, 8'h67, 8'h65, 8'h72};

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_message;
    } sym_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  byte_value;
        logic [9:0]  byte_index;
        logic [1:0]  verdict;
        logic [10:0] total_length;
    } res_t;

endpackage

// ----- hw/rtl/hex_fragment_reassembly_parser.sv -----
// Fragment reassembly parser for hex-coded messages: top level.
//
// Usage: message characters enter one word at a time on the sym channel
// (sym_valid, sym_stall, sym). A word with end_of_message set closes the
// message and its symbol is ignored. Results leave on the res channel
// (res_valid, res_stall, res): one decoded data byte for every second data
// character of an accepted fragment, and one verdict word per terminator.
// Characters that produce nothing are consumed silently.
// The input register holds the accepted character while the parser logic
// feeds the result register, from which the receiver takes the result word.
// Throughput is one word per cycle while the receiver does not stall; the state
// update for each character is a single pass through short logic between those two registers.
// After reset the kept fragment id, count and byte index are zero and the
// parser waits for the first field of a new message.
// When the receiver stalls, the result word holds; the input register then
// fills and sym_stall rises until the result is taken.
module hex_fragment_reassembly_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sym_valid,
    output logic          sym_stall,
    input  hfrp_pkg::sym_t sym,
    output logic          res_valid,
    input  logic          res_stall,
    output hfrp_pkg::res_t res
);
    import hfrp_pkg::*;

    `include "hex_fragment_reassembly_parser_macros.svh"

    logic             s1_valid_reg, s1_valid_next;
    sym_t             s1_item_reg, s1_item_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_reg, res_next;

    logic [7:0]       last_id_reg, last_id_next;
    logic [7:0]       frag_count_reg, frag_count_next;
    logic [NIB_W-1:0] nib_index_reg, nib_index_next;
    logic [7:0]       pending_reg, pending_next;
    logic [2:0]       field_reg, field_next;
    logic             delim_run_reg, delim_run_next;
    logic [3:0]       flag_reg, flag_next;
    logic [8:0]       acc_reg, acc_next;
    logic [7:0]       header_id_reg, header_id_next;
    logic [1:0]       decision_reg, decision_next;

    logic             res_ready;
    logic             advance;
    logic             emit;
    res_t             result;
    logic [NIB_W-1:0] half_index;
    logic [4:0]       hex;
    logic [11:0]      acc_times_ten;
    logic [7:0]       c;

    function automatic logic [4:0] hex_decode(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch inside {[8'h30:8'h39]})
        begin
            r = {1'b1, 4'(ch - 8'h30)};
        end
        else if (ch inside {[8'h41:8'h46]})
        begin
            r = {1'b1, 4'(ch - 8'h37)};
        end
        else if (ch inside {[8'h61:8'h66]})
        begin
            r = {1'b1, 4'(ch - 8'h57)};
        end
        return r;
    endfunction

    assign res_ready = !res_valid_reg || !res_stall;
    assign advance   = s1_valid_reg && res_ready;
    assign sym_stall = s1_valid_reg && !res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign c         = s1_item_reg.symbol;
    assign hex       = hex_decode(c);
    assign half_index = nib_index_reg >> 1;

    // Input register: a new word enters whenever the held one moves on.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;
        if (!sym_stall)
        begin
            s1_valid_next = sym_valid;
            s1_item_next  = sym;
        end
    end

    // Parser state update for the word in the input register.
    always_comb
    begin
        last_id_next    = last_id_reg;
        frag_count_next = frag_count_reg;
        nib_index_next  = nib_index_reg;
        pending_next    = pending_reg;
        field_next      = field_reg;
        delim_run_next  = delim_run_reg;
        flag_next       = flag_reg;
        acc_next        = acc_reg;
        header_id_next  = header_id_reg;
        decision_next   = decision_reg;
        emit            = 1'b0;
        result          = '0;
        acc_times_ten   = '0;

        if (s1_item_reg.end_of_message)
        begin
            emit        = 1'b1;
            result.kind = KIND_VERDICT;
            if (flag_reg == FLAG_TRIG)
            begin
                result.verdict = VERDICT_TRIGGER;
            end
            else if (decision_reg == DEC_ACCEPT && frag_count_reg != 8'd0 &&
                     ({1'b0, last_id_reg} + 9'd1) == {1'b0, frag_count_reg})
            begin
                result.verdict      = VERDICT_COMPLETE;
                result.total_length = 11'(half_index);
            end
            field_next     = FIELD_NONE;
            delim_run_next = 1'b1;
            flag_next      = FLAG_EMPTY;
            acc_next       = '0;
            header_id_next = '0;
            decision_next  = DEC_UNDECIDED;
        end
        else if (field_reg != FIELD_STOP)
        begin
            if (c == CHAR_NUL)
            begin
                field_next = FIELD_STOP;
            end
            else if (c == CHAR_SEMI || c == CHAR_CR || c == CHAR_LF)
            begin
                delim_run_next = 1'b1;
            end
            else
            begin
                // The first character after a delimiter run opens the next field, up to the extra field.
                if (delim_run_reg)
                begin
                    delim_run_next = 1'b0;
                    case (field_reg)
                        FIELD_FLAG:
                        begin
                            acc_next = '0;
                        end
                        FIELD_ID:
                        begin
                            header_id_next = acc_reg[7:0];
                            acc_next       = '0;
                        end
                        FIELD_COUNT:
                        begin
                            if (flag_reg != FLAG_F)
                            begin
                                decision_next = DEC_REJECT;
                            end
                            else if (header_id_reg == 8'd0)
                            begin
                                decision_next   = DEC_ACCEPT;
                                last_id_next    = 8'd0;
                                frag_count_next = acc_reg[7:0];
                                nib_index_next  = '0;
                            end
                            else if (({1'b0, last_id_reg} + 9'd1) == {1'b0, header_id_reg} &&
                                     frag_count_reg == acc_reg[7:0])
                            begin
                                decision_next = DEC_ACCEPT;
                                last_id_next  = header_id_reg;
                            end
                            else
                            begin
                                decision_next = DEC_REJECT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (field_reg < FIELD_EXTRA)
                    begin
                        field_next = field_reg + 3'd1;
                    end
                end

                case (field_next)
                    FIELD_FLAG:
                    begin
                        if (flag_reg == FLAG_EMPTY)
                        begin
                            flag_next = (c == CHAR_AT) ? FLAG_AT : FLAG_BAD;
                        end
                        else if (flag_reg inside {[4'd1:4'd7]})
                        begin
                            if (c == TRIG_CHARS[flag_reg[2:0]])
                            begin
                                flag_next = flag_reg + 4'd1;
                            end
                            else if (flag_reg == FLAG_AT && c == CHAR_F)
                            begin
                                flag_next = FLAG_F;
                            end
                            else
                            begin
                                flag_next = FLAG_BAD;
                            end
                        end
                        else if (flag_reg != FLAG_TRIG)
                        begin
                            flag_next = FLAG_BAD;
                        end
                    end
                    FIELD_ID, FIELD_COUNT:
                    begin
                        if (!acc_next[8])
                        begin
                            if (c inside {[8'h30:8'h39]})
                            begin
                                acc_times_ten = {1'b0, acc_next[7:0], 3'b000} +
                                                {3'b000, acc_next[7:0], 1'b0} +
                                                {8'd0, 4'(c - 8'h30)};
                                acc_next = (acc_times_ten > 12'd255) ? 9'd255 :
                                           {1'b0, acc_times_ten[7:0]};
                            end
                            else
                            begin
                                acc_next[8] = 1'b1;
                            end
                        end
                    end
                    FIELD_DATA:
                    begin
                        if (decision_next == DEC_ACCEPT && nib_index_next < NIB_LIMIT)
                        begin
                            if (!nib_index_next[0])
                            begin
                                if (hex[4])
                                begin
                                    pending_next = {4'd0, hex[3:0]};
                                end
                            end
                            else
                            begin
                                pending_next      = {pending_reg[3:0],
                                                     hex[4] ? hex[3:0] : 4'd0};
                                emit              = 1'b1;
                                result.kind       = KIND_BYTE;
                                result.byte_value = pending_next;
                                result.byte_index = 10'(nib_index_next >> 1);
                            end
                            nib_index_next = nib_index_next + NIB_W'(1);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_ready)
        begin
            res_valid_next = advance && emit;
            res_next       = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            last_id_reg    <= '0;
            frag_count_reg <= '0;
            nib_index_reg  <= '0;
            pending_reg    <= '0;
            field_reg      <= FIELD_NONE;
            delim_run_reg  <= 1'b1;
            flag_reg       <= FLAG_EMPTY;
            acc_reg        <= '0;
            header_id_reg  <= '0;
            decision_reg   <= DEC_UNDECIDED;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                last_id_reg    <= last_id_next;
                frag_count_reg <= frag_count_next;
                nib_index_reg  <= nib_index_next;
                pending_reg    <= pending_next;
                field_reg      <= field_next;
                delim_run_reg  <= delim_run_next;
                flag_reg       <= flag_next;
                acc_reg        <= acc_next;
                header_id_reg  <= header_id_next;
                decision_reg   <= decision_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        res_reg     <= res_next;
    end

    `HFRP_ASSERT_NOW(a_nib_bound, 1'b1, nib_index_reg <= NIB_LIMIT)
    `HFRP_ASSERT_NOW(a_byte_clean, res_valid_reg && res_reg.kind == KIND_BYTE,
        res_reg.verdict == VERDICT_NONE && res_reg.total_length == 11'd0)
    `HFRP_ASSERT_NOW(a_len_only_complete,
        res_valid_reg && res_reg.verdict != VERDICT_COMPLETE,
        res_reg.total_length == 11'd0)
    `HFRP_ASSERT_NEXT(a_stall_holds_word, sym_stall, s1_valid_reg && $stable(s1_item_reg))

endmodule
